/* hdl/mcg_pkg.sv */
// shared types and constants for the motor current guard
package mcg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 88;
    localparam int QUO_W      = 15;
    localparam int NUM_W      = 30;
    localparam int DIV_CNT_W  = 4;

    localparam logic [QUO_W-1:0] PERMILLE_MAX = 15'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STALL_CURRENT  = 3'd0,
        REG_SOFT_LIMIT     = 3'd1,
        REG_DEBOUNCE       = 3'd2,
        REG_OBSERVE_ONLY   = 3'd3,
        REG_SOFT_LIMIT_ON  = 3'd4,
        REG_ENABLE_MASK    = 3'd5
    } mcg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_START,
        ST_DIV,
        ST_DONE
    } mcg_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mcg_div_stat_t;

endpackage

/* hdl/mcg_divider.sv */
// restoring divider, one quotient bit per cycle
module mcg_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mcg_pkg::NUM_W-1:0]     numerator,
    input  logic [mcg_pkg::QUO_W-1:0]     divisor,
    output logic [mcg_pkg::QUO_W-1:0]     quotient,
    output mcg_pkg::mcg_div_stat_t        stat
);

    logic [mcg_pkg::QUO_W-1:0]     rem_reg, rem_next;
    logic [mcg_pkg::QUO_W-1:0]     nq_reg, nq_next;
    logic [mcg_pkg::QUO_W-1:0]     den_reg;
    logic [mcg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [mcg_pkg::QUO_W:0]       trial;
    logic [mcg_pkg::QUO_W+1:0]     diff;
    logic                          qbit;

    // partial remainder held in 15 bits; it stays below the divisor only if the numerator's upper half starts below it
    always_comb begin
        trial = {rem_reg, nq_reg[mcg_pkg::QUO_W-1]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
        qbit  = ~diff[mcg_pkg::QUO_W+1];
    end

    always_comb begin
        rem_next  = rem_reg;
        nq_next   = nq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = numerator[mcg_pkg::NUM_W-1:mcg_pkg::QUO_W];
            nq_next   = numerator[mcg_pkg::QUO_W-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? diff[mcg_pkg::QUO_W-1:0] : trial[mcg_pkg::QUO_W-1:0];
            nq_next  = {nq_reg[mcg_pkg::QUO_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mcg_pkg::DIV_CNT_W'(mcg_pkg::QUO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        if (start) begin
            den_reg <= divisor;
        end
    end

    assign quotient  = nq_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* hdl/motor_current_guard.sv */
// top level of the motor current guard: sequencer, per-motor counters and output register
//
// One transfer in gives one transfer out. An accepted item passes through the evaluate and done
// states when the drive is not scaled; when soft limiting scales it, the evaluate state runs a
// 16x15 multiply and the start and divide states then run a shared restoring divider, one
// quotient bit per cycle. The result sits in an output register, so a new item is taken while
// an earlier result waits on m_tready. Per-motor state is cleared by reset.
module motor_current_guard #(
    parameter int MOTORS = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mcg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // motor_index, request, measured_ma, sensor_valid, valid_mask, zero pad
    input  logic [mcg_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // drive, was_limited, reading_valid, over_stall, soft_would_apply,
    // fault hit, over_stall_total, fault_total, zero pad
    output logic [mcg_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    // configuration
    logic [14:0] stall_reg;
    logic [14:0] soft_limit_reg;
    logic [7:0]  debounce_reg;
    logic        observe_reg;
    logic        soft_on_reg;
    logic [7:0]  enable_reg;

    // accepted item
    logic [2:0]  motor_reg;
    logic [15:0] req_reg;
    logic [15:0] meas_reg;
    logic        sensor_reg;
    logic [7:0]  vmask_reg;

    // per-motor state
    logic [7:0]  deb_mem  [MOTORS];
    logic [31:0] os_mem   [MOTORS];
    logic [31:0] fc_mem   [MOTORS];

    // evaluated result
    logic [15:0] applied_reg;
    logic        limited_reg;
    logic        rvalid_reg;
    logic        over_reg;
    logic        soft_reg;
    logic        fault_reg;
    logic [31:0] os_tot_reg;
    logic [31:0] fc_tot_reg;
    logic [29:0] prod_reg;
    logic [14:0] den_reg;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [mcg_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    mcg_pkg::mcg_state_t state_reg, state_next;

    // control
    logic in_accept;
    logic eval_en;
    logic div_start;
    logic load_out;

    // evaluation
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             en_bit;
    logic             active;
    logic             over;
    logic             soft_hit;
    logic             fault;
    logic             limit_go;
    logic [7:0]       deb_cur;
    logic [7:0]       deb_new;
    logic [31:0]      os_new;
    logic [31:0]      fc_new;
    logic [15:0]      mag_req;
    logic [30:0]      prod_full;
    logic [15:0]      applied_pass;

    // divider
    logic [mcg_pkg::QUO_W-1:0] quo;
    logic [mcg_pkg::QUO_W-1:0] quo_clamped;
    logic [15:0]               applied_div;
    logic [15:0]               applied_final;
    mcg_pkg::mcg_div_stat_t    div_stat;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stall_reg      <= '0;
            soft_limit_reg <= '0;
            debounce_reg   <= '0;
            observe_reg    <= 1'b1;
            soft_on_reg    <= 1'b0;
            enable_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mcg_pkg::REG_STALL_CURRENT: stall_reg      <= cfg_wdata;
                mcg_pkg::REG_SOFT_LIMIT:    soft_limit_reg <= cfg_wdata;
                mcg_pkg::REG_DEBOUNCE:      debounce_reg   <= cfg_wdata[7:0];
                mcg_pkg::REG_OBSERVE_ONLY:  observe_reg    <= cfg_wdata[0];
                mcg_pkg::REG_SOFT_LIMIT_ON: soft_on_reg    <= cfg_wdata[0];
                mcg_pkg::REG_ENABLE_MASK:   enable_reg     <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mcg_pkg::ST_IDLE:  if (s_tvalid) state_next = mcg_pkg::ST_EVAL;
            mcg_pkg::ST_EVAL:  state_next = limit_go ? mcg_pkg::ST_START : mcg_pkg::ST_DONE;
            mcg_pkg::ST_START: state_next = mcg_pkg::ST_DIV;
            mcg_pkg::ST_DIV:   if (div_stat.done) state_next = mcg_pkg::ST_DONE;
            mcg_pkg::ST_DONE:  if (!m_tvalid_reg || m_tready) state_next = mcg_pkg::ST_IDLE;
            default:           state_next = mcg_pkg::ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_tready  = 1'b0;
        eval_en   = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            mcg_pkg::ST_IDLE:  s_tready  = aresetn;
            mcg_pkg::ST_EVAL:  eval_en   = 1'b1;
            mcg_pkg::ST_START: div_start = 1'b1;
            mcg_pkg::ST_DIV:   ;
            mcg_pkg::ST_DONE:  load_out  = ~m_tvalid_reg | m_tready;
            default:           ;
        endcase
    end

    assign in_accept = s_tvalid & s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mcg_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            motor_reg  <= s_tdata[2:0];
            req_reg    <= s_tdata[18:3];
            meas_reg   <= s_tdata[34:19];
            sensor_reg <= s_tdata[35];
            vmask_reg  <= s_tdata[43:36];
        end
    end

    // evaluation of one item
    always_comb begin
        idx      = motor_reg[IDX_W-1:0];
        in_range = {1'b0, motor_reg} < 4'(MOTORS);
        en_bit   = enable_reg[motor_reg];
        active   = in_range & en_bit & sensor_reg & vmask_reg[motor_reg];
        deb_cur  = deb_mem[idx];

        over = active & ($signed({meas_reg[15], meas_reg}) > $signed({2'b00, stall_reg}));
        soft_hit = active & (soft_limit_reg != '0) & (req_reg != '0)
                 & ($signed({meas_reg[15], meas_reg}) > $signed({2'b00, soft_limit_reg}));

        if (over) begin
            deb_new = (deb_cur < debounce_reg) ? deb_cur + 8'd1 : deb_cur;
        end else begin
            deb_new = 8'd0;
        end
        fault    = over & (deb_new >= debounce_reg);
        limit_go = soft_hit & ~observe_reg & soft_on_reg;

        os_new = os_mem[idx] + {31'd0, over};
        fc_new = fc_mem[idx] + {31'd0, fault};

        mag_req      = req_reg[15] ? (~req_reg + 16'd1) : req_reg;
        prod_full    = {15'd0, mag_req} * {16'd0, soft_limit_reg};
        applied_pass = (in_range & en_bit) ? req_reg : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MOTORS; i++) begin
                deb_mem[i] <= '0;
                os_mem[i]  <= '0;
                fc_mem[i]  <= '0;
            end
        end else if (eval_en && active) begin
            deb_mem[idx] <= deb_new;
            os_mem[idx]  <= os_new;
            fc_mem[idx]  <= fc_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_en) begin
            applied_reg <= applied_pass;
            limited_reg <= limit_go;
            rvalid_reg  <= active;
            over_reg    <= over;
            soft_reg    <= soft_hit;
            fault_reg   <= fault;
            os_tot_reg  <= in_range ? os_new : 32'd0;
            fc_tot_reg  <= in_range ? fc_new : 32'd0;
            prod_reg    <= prod_full[29:0];
            den_reg     <= meas_reg[14:0];
        end
    end

    mcg_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .numerator (prod_reg),
        .divisor   (den_reg),
        .quotient  (quo),
        .stat      (div_stat)
    );

    // clamp the quotient, restore the sign of the request and select the scaled or passed drive
    always_comb begin
        quo_clamped   = (quo > mcg_pkg::PERMILLE_MAX) ? mcg_pkg::PERMILLE_MAX : quo;
        applied_div   = req_reg[15] ? (~{1'b0, quo_clamped} + 16'd1) : {1'b0, quo_clamped};
        applied_final = limited_reg ? applied_div : applied_reg;
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {3'd0, fc_tot_reg, os_tot_reg, fault_reg, soft_reg, over_reg,
                            rvalid_reg, limited_reg, applied_final};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a new transfer is taken only from the idle state
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("item accepted while one is in progress");

    // divider runs only while the sequencer waits on it
    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> state_reg == mcg_pkg::ST_DIV)
        else $error("divider busy outside the divide state");

    // scaled drive always within the permille range
    a_limited_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[16]) |->
            ($signed(m_tdata[15:0]) <= 16'sd1000 && $signed(m_tdata[15:0]) >= -16'sd1000))
        else $error("scaled drive outside range");

    // flags only on a valid reading
    a_flags_need_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[17]) |-> (m_tdata[20:18] == 3'b000 && !m_tdata[16]))
        else $error("flag raised without a valid reading");

endmodule

/* tb/sv/motor_current_guard_test.sv */
// testbench for the motor current guard: directed and random transfers checked against a predictor
`timescale 1ns / 100ps

module motor_current_guard_test;

    localparam int GUARD_MOTORS = 4;

    typedef struct packed {
        logic [7:0]         valid_mask;
        logic               sensor_valid;
        logic signed [15:0] measured_ma;
        logic signed [15:0] requested;
        logic [2:0]         motor;
    } guard_cmd_t;

    typedef struct packed {
        logic [31:0]        fault_total;
        logic [31:0]        over_stall_total;
        logic               fault_hit;
        logic               soft_would_apply;
        logic               over_stall;
        logic               reading_valid;
        logic               was_limited;
        logic signed [15:0] applied;
    } guard_res_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [mcg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mcg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mcg_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mcg_pkg::OUT_DATA_W-1:0] m_tdata;

    // shadow of the guard registers
    logic [14:0] stall_ma_q;
    logic [14:0] soft_ma_q;
    logic [7:0]  deb_target_q;
    logic        observe_q;
    logic        soft_on_q;
    logic [7:0]  en_mask_q;

    // shadow of the per-motor state
    logic [7:0]  deb_cnt [GUARD_MOTORS];
    logic [31:0] stall_cnt [GUARD_MOTORS];
    logic [31:0] fault_cnt [GUARD_MOTORS];

    guard_res_t expected_drive_q[$];
    int         mismatches = 0;
    bit         quiet = 1'b0;
    int         ready_hold = 0;

    motor_current_guard #(
        .MOTORS(GUARD_MOTORS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic guard_res_t predict_drive(guard_cmd_t c);
        guard_res_t r;
        int m;
        int req_i;
        int cur_i;
        int prod;
        int quo;
        r = '0;
        m = c.motor;
        req_i = $signed(c.requested);
        cur_i = $signed(c.measured_ma);
        if (m >= GUARD_MOTORS) return r;
        r.over_stall_total = stall_cnt[m];
        r.fault_total = fault_cnt[m];
        if (!en_mask_q[m]) return r;
        r.applied = c.requested;
        if (!c.sensor_valid || !c.valid_mask[m]) return r;
        r.reading_valid = 1'b1;
        if (cur_i > int'(stall_ma_q)) begin
            r.over_stall = 1'b1;
            stall_cnt[m] = stall_cnt[m] + 32'd1;
            if (deb_cnt[m] < deb_target_q) deb_cnt[m] = deb_cnt[m] + 8'd1;
        end else begin
            deb_cnt[m] = '0;
        end
        if (soft_ma_q != 0 && cur_i > int'(soft_ma_q) && req_i != 0) r.soft_would_apply = 1'b1;
        if (r.over_stall && deb_cnt[m] >= deb_target_q) begin
            r.fault_hit = 1'b1;
            fault_cnt[m] = fault_cnt[m] + 32'd1;
        end
        if (!observe_q && soft_on_q && r.soft_would_apply) begin
            prod = req_i * int'(soft_ma_q);
            quo = prod / cur_i;
            if (quo > 1000) quo = 1000;
            if (quo < -1000) quo = -1000;
            r.applied = quo[15:0];
            r.was_limited = 1'b1;
        end
        r.over_stall_total = stall_cnt[m];
        r.fault_total = fault_cnt[m];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, want %h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch(field, got, want);
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        guard_res_t got;
        guard_res_t want;
        int r;
        if (aresetn && m_tvalid && m_tready) begin
            got = guard_res_t'(m_tdata[$bits(guard_res_t)-1:0]);
            if (expected_drive_q.size() == 0) begin
                report_mismatch("unexpected transfer", 32'h0, 32'h0);
            end else begin
                want = expected_drive_q.pop_front();
                check_field("applied", 32'(got.applied), 32'(want.applied));
                check_field("was_limited", 32'(got.was_limited), 32'(want.was_limited));
                check_field("reading_valid", 32'(got.reading_valid), 32'(want.reading_valid));
                check_field("over_stall", 32'(got.over_stall), 32'(want.over_stall));
                check_field("soft_would_apply", 32'(got.soft_would_apply),
                            32'(want.soft_would_apply));
                check_field("fault_hit", 32'(got.fault_hit), 32'(want.fault_hit));
                check_field("over_stall_total", got.over_stall_total, want.over_stall_total);
                check_field("fault_total", got.fault_total, want.fault_total);
            end
        end
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_tready <= 1'b1;
                ready_hold = $urandom_range(0, 7);
            end else if (r < 92) begin
                m_tready <= 1'b0;
                ready_hold = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b0;
                ready_hold = $urandom_range(20, 60);
            end
        end
    end

    task automatic idle_gap();
        int r;
        int n;
        if (quiet) return;
        r = $urandom_range(0, 99);
        if (r < 50) n = 0;
        else if (r < 90) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 40);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_cmd(guard_cmd_t c);
        s_tvalid <= 1'b1;
        s_tdata <= {{(mcg_pkg::IN_DATA_W - $bits(guard_cmd_t)){1'b0}}, c};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_drive_q.push_back(predict_drive(c));
        idle_gap();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_drive_q.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_reg(mcg_pkg::mcg_reg_t idx, logic [14:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            mcg_pkg::REG_STALL_CURRENT: stall_ma_q = val;
            mcg_pkg::REG_SOFT_LIMIT:    soft_ma_q = val;
            mcg_pkg::REG_DEBOUNCE:      deb_target_q = val[7:0];
            mcg_pkg::REG_OBSERVE_ONLY:  observe_q = val[0];
            mcg_pkg::REG_SOFT_LIMIT_ON: soft_on_q = val[0];
            mcg_pkg::REG_ENABLE_MASK:   en_mask_q = val[7:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_config(int stall, int soft_lim, int deb, int obs, int son, int mask);
        drain();
        write_reg(mcg_pkg::REG_STALL_CURRENT, stall[14:0]);
        write_reg(mcg_pkg::REG_SOFT_LIMIT, soft_lim[14:0]);
        write_reg(mcg_pkg::REG_DEBOUNCE, deb[14:0]);
        write_reg(mcg_pkg::REG_OBSERVE_ONLY, obs[14:0]);
        write_reg(mcg_pkg::REG_SOFT_LIMIT_ON, son[14:0]);
        write_reg(mcg_pkg::REG_ENABLE_MASK, mask[14:0]);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic guard_cmd_t make_cmd(int motor, int req, int cur, bit sv, int vmask);
        guard_cmd_t c;
        c.motor = motor[2:0];
        c.requested = req[15:0];
        c.measured_ma = cur[15:0];
        c.sensor_valid = sv;
        c.valid_mask = vmask[7:0];
        return c;
    endfunction

    function automatic int pick_current();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return int'($urandom_range(0, 65535));
            1: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            2, 3, 4: return int'(stall_ma_q) + int'($urandom_range(0, 6)) - 3;
            5, 6, 7: return int'(soft_ma_q) + int'($urandom_range(0, 100)) - 50;
            8: return int'($urandom_range(0, 2000));
            default: return -int'($urandom_range(1, 2000));
        endcase
    endfunction

    function automatic int pick_request();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1: return int'($urandom_range(0, 65535));
            2: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            3: return 0;
            default: return int'($urandom_range(0, 2400)) - 1200;
        endcase
    endfunction

    function automatic guard_cmd_t random_cmd();
        int m;
        int vmask;
        m = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(4, 7);
        vmask = $urandom_range(0, 255);
        if ($urandom_range(0, 99) < 90) vmask[m] = 1'b1;
        return make_cmd(m, pick_request(), pick_current(), $urandom_range(0, 99) < 92, vmask);
    endfunction

    task automatic test_reset_state();
        send_cmd(make_cmd(1, 700, 900, 1'b1, 8'hFF));
        send_cmd(make_cmd(5, -700, 900, 1'b1, 8'hFF));
    endtask

    task automatic test_out_of_range_and_invalid();
        apply_config(500, 300, 2, 0, 1, 8'h0F);
        send_cmd(make_cmd(4, 900, 900, 1'b1, 8'hFF));
        send_cmd(make_cmd(7, 900, 900, 1'b1, 8'hFF));
        send_cmd(make_cmd(0, 1234, 900, 1'b0, 8'hFF));
        send_cmd(make_cmd(1, -1234, 900, 1'b1, 8'hFD));
    endtask

    task automatic test_stall_debounce();
        repeat (3) send_cmd(make_cmd(2, 0, 600, 1'b1, 8'h04));
        send_cmd(make_cmd(2, 0, 100, 1'b1, 8'h04));
        send_cmd(make_cmd(2, 0, 600, 1'b1, 8'h04));
    endtask

    task automatic test_soft_scaling();
        send_cmd(make_cmd(3, 1000, 600, 1'b1, 8'hFF));
        send_cmd(make_cmd(3, -32768, 32767, 1'b1, 8'hFF));
        send_cmd(make_cmd(3, 32767, 301, 1'b1, 8'hFF));
        send_cmd(make_cmd(3, 0, 1000, 1'b1, 8'hFF));
        send_cmd(make_cmd(3, -1000, -32768, 1'b1, 8'hFF));
    endtask

    task automatic test_zero_target_and_limit();
        apply_config(0, 0, 0, 1, 1, 8'hFF);
        send_cmd(make_cmd(0, 5, 1, 1'b1, 8'hFF));
        send_cmd(make_cmd(1, 32767, 32767, 1'b1, 8'hFF));
    endtask

    task automatic test_observe_only();
        apply_config(32767, 1, 255, 1, 1, 8'hFF);
        send_cmd(make_cmd(2, 500, 2, 1'b1, 8'hFF));
        apply_config(32767, 1, 255, 0, 0, 8'hFF);
        send_cmd(make_cmd(2, 500, 2, 1'b1, 8'hFF));
        apply_config(32767, 1, 255, 0, 1, 8'hFF);
        send_cmd(make_cmd(2, 500, 2, 1'b1, 8'hFF));
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: apply_config(400, 250, 3, 0, 1, 8'hFF);
                1: apply_config(0, 0, 0, 1, 0, 8'h0F);
                2: apply_config(32767, 32767, 255, 0, 1, 8'hFF);
                3: apply_config($urandom_range(0, 3000), $urandom_range(1, 3000),
                                $urandom_range(0, 6), 0, 1, $urandom_range(0, 255));
                4: apply_config(1000, 1, 1, 0, 1, 8'h05);
                5: apply_config($urandom_range(0, 32767), $urandom_range(0, 32767),
                                $urandom_range(0, 255), $urandom_range(0, 1),
                                $urandom_range(0, 1), $urandom_range(0, 255));
                6: apply_config(200, 800, 2, 0, 1, 8'hFF);
                default: apply_config(50, 100, 4, 1, 1, 8'hAA);
            endcase
            quiet = (phase == 3);
            for (int i = 0; i < 110; i++) begin
                send_cmd(random_cmd());
                // hold off until the pipeline is empty
                if (phase == 6 && i == 55) drain();
            end
            quiet = 1'b0;
        end
    endtask

    initial begin
        stall_ma_q = '0;
        soft_ma_q = '0;
        deb_target_q = '0;
        observe_q = 1'b1;
        soft_on_q = 1'b0;
        en_mask_q = '0;
        for (int m = 0; m < GUARD_MOTORS; m++) begin
            deb_cnt[m] = '0;
            stall_cnt[m] = '0;
            fault_cnt[m] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_out_of_range_and_invalid();
        test_stall_debounce();
        test_soft_scaling();
        test_zero_target_and_limit();
        test_observe_only();
        test_random_traffic();

        drain();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("timeout with %0d transfers outstanding", expected_drive_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
